[rtl/core/frma_pkg.sv]
// shared types, constants and helper functions for the frame rate moving average unit
`default_nettype none

package frma_pkg;

  // sizing of the history ring and the interval input
  localparam int WINDOW_DEPTH  = 128;
  localparam int INTERVAL_BITS = 20;

  // fixed field widths
  localparam int RATE_W = 24;
  localparam int WIN_W  = 8;
  localparam int HELD_W = 8;

  // derived widths
  localparam int SLOT_W     = $clog2(WINDOW_DEPTH);
  localparam int CNT_W      = (SLOT_W + 1 > HELD_W) ? SLOT_W + 1 : HELD_W;
  localparam int SUM_W      = RATE_W + SLOT_W;
  localparam int DIV_W_RAW  = (SUM_W > 28) ? SUM_W : 28;
  localparam int DIV_W      = DIV_W_RAW + (DIV_W_RAW % 2);
  localparam int DVSR_W     = (INTERVAL_BITS > HELD_W) ? INTERVAL_BITS : HELD_W;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  // constants
  localparam logic [RATE_W-1:0] RATE_MAX       = {RATE_W{1'b1}};
  localparam logic [DIV_W-1:0]  RATE_NUMERATOR = DIV_W'(256000000);
  localparam logic [WIN_W-1:0]  WINDOW_RESET   = WIN_W'(100);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_UPDATE,
    ST_AVG,
    ST_HOLD
  } frma_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic cfg_write;
    logic accept;
    logic update;
    logic out_load;
  } frma_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } frma_sts_t;

  // window register value clamped into 1..WINDOW_DEPTH
  function automatic logic [HELD_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    logic [HELD_W-1:0] len;
    if (w == '0) begin
      len = HELD_W'(1);
    end else if (int'(w) > WINDOW_DEPTH) begin
      len = HELD_W'(WINDOW_DEPTH);
    end else begin
      len = HELD_W'(w);
    end
    return len;
  endfunction

  // saturate a quotient into the q16.8 rate range
  function automatic logic [RATE_W-1:0] sat_rate(input logic [DIV_W-1:0] q);
    logic [RATE_W-1:0] r;
    if (q > DIV_W'(RATE_MAX)) begin
      r = RATE_MAX;
    end else begin
      r = q[RATE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/frame_rate_moving_average_unit.sv]
// top level: frame rate moving average unit
// an item is accepted only in idle; its result is loaded after the rate division, ring update and mean division
// next item can be taken the cycle after the result is loaded, so only one item is in flight at a time
// one radix-4 divider is used twice per item, first for the rate and then for the mean
// synchronous active-low reset: window length 100, empty history, no result pending
// history ring contents are not reset; an entry's value is used only after it has been written
`default_nettype none

module frame_rate_moving_average_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [frma_pkg::INTERVAL_BITS-1:0] in_frame_interval_us,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [frma_pkg::RATE_W-1:0]        out_instant_rate,
  output logic      [frma_pkg::RATE_W-1:0]        out_average_rate,
  output logic      [frma_pkg::HELD_W-1:0]        out_samples_held,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [frma_pkg::WIN_W-1:0]         cfg_window_length
);

  frma_pkg::frma_cmd_t cmd;
  frma_pkg::frma_sts_t sts;

  // sequencer
  frma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and storage
  frma_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_window_length    (cfg_window_length),
    .in_frame_interval_us (in_frame_interval_us),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_instant_rate     (out_instant_rate),
    .out_average_rate     (out_average_rate),
    .out_samples_held     (out_samples_held)
  );

endmodule

`default_nettype wire

[rtl/core/frma_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module frma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/frma_div.sv]
// iterative unsigned divider, two quotient bits per cycle
`default_nettype none

module frma_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [frma_pkg::DIV_W-1:0]   dividend,
  input  wire logic [frma_pkg::DVSR_W-1:0]  divisor,
  output logic                              done,
  output logic      [frma_pkg::DIV_W-1:0]   quotient
);

  localparam int DW = frma_pkg::DIV_W;
  localparam int VW = frma_pkg::DVSR_W;
  localparam int CW = frma_pkg::STEP_CNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvsr_r, dvsr_nxt;

  logic [VW:0]   t1, t2;
  logic [VW-1:0] r1, r2;
  logic          b1, b2;

  // two restoring steps
  always_comb begin
    t1 = {rem_r, quo_r[DW-1]};
    b1 = (t1 >= {1'b0, dvsr_r});
    r1 = b1 ? VW'(t1 - {1'b0, dvsr_r}) : t1[VW-1:0];
    t2 = {r1, quo_r[DW-2]};
    b2 = (t2 >= {1'b0, dvsr_r});
    r2 = b2 ? VW'(t2 - {1'b0, dvsr_r}) : t2[VW-1:0];
  end

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvsr_nxt = dvsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvsr_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt = r2;
      quo_nxt = {quo_r[DW-3:0], b1, b2};
      if (cnt_r == CW'(frma_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[rtl/core/frma_dp.sv]
// datapath: window register, history ring, running sum, shared divider, output register
`default_nettype none

module frma_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire frma_pkg::frma_cmd_t                cmd,
  output frma_pkg::frma_sts_t                     sts,
  input  wire logic [frma_pkg::WIN_W-1:0]         cfg_window_length,
  input  wire logic [frma_pkg::INTERVAL_BITS-1:0] in_frame_interval_us,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [frma_pkg::RATE_W-1:0]        out_instant_rate,
  output logic      [frma_pkg::RATE_W-1:0]        out_average_rate,
  output logic      [frma_pkg::HELD_W-1:0]        out_samples_held
);

  localparam int SW  = frma_pkg::SLOT_W;
  localparam int HW  = frma_pkg::HELD_W;
  localparam int CW  = frma_pkg::CNT_W;
  localparam int RW  = frma_pkg::RATE_W;
  localparam int UW  = frma_pkg::SUM_W;
  localparam int DW  = frma_pkg::DIV_W;
  localparam int VW  = frma_pkg::DVSR_W;

  // architectural state
  logic [frma_pkg::WIN_W-1:0] window_r, window_nxt;
  logic [SW-1:0]              write_slot_r, write_slot_nxt;
  logic [HW-1:0]              held_r, held_nxt;
  logic [UW-1:0]              sum_r, sum_nxt;

  // per item working registers
  logic [SW-1:0] slot_r, slot_nxt;
  logic [HW-1:0] len_r, len_nxt;
  logic [RW-1:0] rate_r, rate_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [RW-1:0] out_inst_r, out_inst_nxt;
  logic [RW-1:0] out_avg_r, out_avg_nxt;
  logic [HW-1:0] out_held_r, out_held_nxt;

  // divider and ring signals
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [VW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_quotient;
  logic [RW-1:0] ring_rdata;

  logic [HW-1:0] len_now;
  logic [SW-1:0] slot_now;
  logic [RW-1:0] rate_now;
  logic          full;
  logic [CW-1:0] slot_inc;
  logic [UW-1:0] sum_upd;
  logic [HW-1:0] held_upd;

  // slot and window length for a new item
  always_comb begin
    len_now = frma_pkg::eff_window(window_r);
    if (CW'(write_slot_r) >= CW'(len_now)) begin
      slot_now = '0;
    end else begin
      slot_now = write_slot_r;
    end
  end

  // sum and count after pushing the new rate
  always_comb begin
    rate_now = frma_pkg::sat_rate(div_quotient);
    full     = (held_r >= len_r);
    slot_inc = CW'(slot_r) + CW'(1);
    if (full) begin
      sum_upd  = UW'(sum_r - UW'(ring_rdata) + UW'(rate_now));
      held_upd = len_r;
    end else begin
      sum_upd  = UW'(sum_r + UW'(rate_now));
      held_upd = held_r + HW'(1);
    end
  end

  // divider operand selection
  always_comb begin
    div_start = cmd.accept | cmd.update;
    if (cmd.update) begin
      div_dividend = DW'(sum_upd);
      div_divisor  = VW'(held_upd);
    end else begin
      div_dividend = frma_pkg::RATE_NUMERATOR;
      div_divisor  = VW'(in_frame_interval_us);
    end
  end

  // state updates
  always_comb begin
    window_nxt     = window_r;
    write_slot_nxt = write_slot_r;
    held_nxt       = held_r;
    sum_nxt        = sum_r;
    slot_nxt       = slot_r;
    len_nxt        = len_r;
    rate_nxt       = rate_r;
    if (cmd.cfg_write) begin
      window_nxt     = cfg_window_length;
      write_slot_nxt = '0;
      held_nxt       = '0;
      sum_nxt        = '0;
    end else if (cmd.update) begin
      sum_nxt  = sum_upd;
      held_nxt = held_upd;
      rate_nxt = rate_now;
      if (slot_inc >= CW'(len_r)) begin
        write_slot_nxt = '0;
      end else begin
        write_slot_nxt = SW'(slot_inc);
      end
    end
    if (cmd.accept) begin
      slot_nxt = slot_now;
      len_nxt  = len_now;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_inst_nxt  = out_inst_r;
    out_avg_nxt   = out_avg_r;
    out_held_nxt  = out_held_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_inst_nxt  = rate_r;
      out_avg_nxt   = frma_pkg::sat_rate(div_quotient);
      out_held_nxt  = held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= frma_pkg::WINDOW_RESET;
      write_slot_r <= '0;
      held_r       <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      window_r     <= window_nxt;
      write_slot_r <= write_slot_nxt;
      held_r       <= held_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    len_r      <= len_nxt;
    rate_r     <= rate_nxt;
    out_inst_r <= out_inst_nxt;
    out_avg_r  <= out_avg_nxt;
    out_held_r <= out_held_nxt;
  end

  // history ring, old entry read at accept, new rate written at update
  frma_ram #(
    .WIDTH (RW),
    .DEPTH (frma_pkg::WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot_r),
    .wdata (rate_now),
    .re    (cmd.accept),
    .raddr (slot_now),
    .rdata (ring_rdata)
  );

  // shared divider for rate and mean
  frma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // status
  always_comb begin
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_instant_rate = out_inst_r;
  assign out_average_rate = out_avg_r;
  assign out_samples_held = out_held_r;

endmodule

`default_nettype wire

[rtl/core/frma_ctrl.sv]
// controller state machine sequencing rate division, ring update and mean division
`default_nettype none

module frma_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire frma_pkg::frma_sts_t sts,
  output frma_pkg::frma_cmd_t      cmd
);

  frma_pkg::frma_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frma_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = frma_pkg::ST_RATE;
        end
      end
      frma_pkg::ST_RATE: begin
        if (sts.div_done) begin
          state_nxt = frma_pkg::ST_UPDATE;
        end
      end
      frma_pkg::ST_UPDATE: begin
        state_nxt = frma_pkg::ST_AVG;
      end
      frma_pkg::ST_AVG: begin
        if (sts.div_done) begin
          state_nxt = sts.out_free ? frma_pkg::ST_IDLE : frma_pkg::ST_HOLD;
        end
      end
      frma_pkg::ST_HOLD: begin
        if (sts.out_free) begin
          state_nxt = frma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = frma_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = 1'b1;
    cfg_ready     = 1'b0;
    cmd.cfg_write = 1'b0;
    cmd.accept    = 1'b0;
    cmd.update    = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state_r)
      frma_pkg::ST_IDLE: begin
        // an offered item goes first, the window write waits for the next idle
        in_stall      = 1'b0;
        cfg_ready     = !in_valid;
        cmd.cfg_write = cfg_valid && !in_valid;
        cmd.accept    = in_valid;
      end
      frma_pkg::ST_RATE: begin
      end
      frma_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      frma_pkg::ST_AVG: begin
        cmd.out_load = sts.div_done && sts.out_free;
      end
      frma_pkg::ST_HOLD: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/frma_checker.sv]
// port-level checker for the frame rate moving average unit, with its bind
`default_nettype none

module frma_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [frma_pkg::RATE_W-1:0]        out_instant_rate,
  input wire logic [frma_pkg::RATE_W-1:0]        out_average_rate,
  input wire logic [frma_pkg::HELD_W-1:0]        out_samples_held,
  input wire logic                               cfg_valid,
  input wire logic                               cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_instant_rate)
      && $stable(out_average_rate) && $stable(out_samples_held))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("not busy after item accepted");

  // count in the window is never zero and never exceeds the ring depth
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_samples_held != '0)
      && (int'(out_samples_held) <= frma_pkg::WINDOW_DEPTH))
    else $error("samples held out of range");

  // with one sample held the mean equals the instantaneous rate
  a_single_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_samples_held == frma_pkg::HELD_W'(1))
      |-> out_average_rate == out_instant_rate)
    else $error("mean of one sample differs from rate");

  // config is taken only while the item side is open
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !in_stall)
    else $error("config ready while busy");

endmodule

bind frame_rate_moving_average_unit frma_checker u_frma_checker (.*);

`default_nettype wire

[bench/tb_frame_rate_moving_average_unit.sv]
// testbench for the frame rate moving average unit: scoreboard, drivers and run sequence
`timescale 1ns / 100ps

module tb_frame_rate_moving_average_unit;

  // run sizing
  localparam int unsigned ITEM_TARGET   = 1250;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned EXP_DEPTH     = 8;

  // fps numerator in q16.8 and the reset window
  localparam longint unsigned FPS_Q8_NUMERATOR = 64'd256_000_000;
  localparam logic [frma_pkg::WIN_W-1:0] DEFAULT_WINDOW = frma_pkg::WINDOW_RESET;

  typedef struct packed {
    logic [frma_pkg::RATE_W-1:0] instant;
    logic [frma_pkg::RATE_W-1:0] average;
    logic [frma_pkg::HELD_W-1:0] held;
  } rate_result_t;

  // predicts the block and checks its results in order
  class rate_window_scoreboard;
    bit [frma_pkg::RATE_W-1:0]   rate_ring [frma_pkg::WINDOW_DEPTH];
    int unsigned                 next_slot;
    int unsigned                 held;
    longint unsigned             rate_sum;
    logic [frma_pkg::WIN_W-1:0]  window_reg;
    rate_result_t                expected_fifo [EXP_DEPTH];
    int unsigned                 exp_rd;
    int unsigned                 exp_wr;
    int unsigned                 exp_count;
    int unsigned                 checked;
    int unsigned                 mismatches;

    function new();
      window_reg = DEFAULT_WINDOW;
      next_slot  = 0;
      held       = 0;
      rate_sum   = 0;
      exp_rd     = 0;
      exp_wr     = 0;
      exp_count  = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    // a window write also empties the history
    function void set_window(logic [frma_pkg::WIN_W-1:0] w);
      window_reg = w;
      next_slot  = 0;
      held       = 0;
      rate_sum   = 0;
    endfunction

    function void note_interval(logic [frma_pkg::INTERVAL_BITS-1:0] us);
      int unsigned                 span;
      longint unsigned             quot;
      bit [frma_pkg::RATE_W-1:0]   rate;
      rate_result_t                exp_r;
      // window register clamped into 1..depth
      if (window_reg == '0) begin
        span = 1;
      end else if (int'(window_reg) > frma_pkg::WINDOW_DEPTH) begin
        span = frma_pkg::WINDOW_DEPTH;
      end else begin
        span = int'(window_reg);
      end
      // instantaneous rate, zero interval and short intervals saturate
      if (us == '0) begin
        rate = frma_pkg::RATE_MAX;
      end else begin
        quot = FPS_Q8_NUMERATOR / longint'(us);
        rate = (quot > longint'(frma_pkg::RATE_MAX)) ? frma_pkg::RATE_MAX
                                                      : quot[frma_pkg::RATE_W-1:0];
      end
      // ring update, the oldest rate leaves once the window is full
      if (next_slot >= span) next_slot = 0;
      if (held >= span) begin
        rate_sum -= longint'(rate_ring[next_slot]);
        held = span;
      end else begin
        held++;
      end
      rate_ring[next_slot] = rate;
      rate_sum += longint'(rate);
      next_slot = (next_slot + 1 >= span) ? 0 : next_slot + 1;
      exp_r.instant = rate;
      exp_r.average = frma_pkg::RATE_W'(rate_sum / held);
      exp_r.held    = frma_pkg::HELD_W'(held);
      if (exp_count == EXP_DEPTH) begin
        $error("expected results overflow");
        mismatches++;
        return;
      end
      expected_fifo[exp_wr] = exp_r;
      exp_wr = (exp_wr + 1) % EXP_DEPTH;
      exp_count++;
    endfunction

    function void check_result(rate_result_t got);
      rate_result_t exp_r;
      if (exp_count == 0) begin
        $error("result with nothing expected: instant_rate %0d average_rate %0d samples_held %0d",
               got.instant, got.average, got.held);
        mismatches++;
        return;
      end
      exp_r = expected_fifo[exp_rd];
      exp_rd = (exp_rd + 1) % EXP_DEPTH;
      exp_count--;
      checked++;
      if (got.instant !== exp_r.instant) begin
        $error("instant_rate: expected %0d, got %0d", exp_r.instant, got.instant);
        mismatches++;
      end
      if (got.average !== exp_r.average) begin
        $error("average_rate: expected %0d, got %0d", exp_r.average, got.average);
        mismatches++;
      end
      if (got.held !== exp_r.held) begin
        $error("samples_held: expected %0d, got %0d", exp_r.held, got.held);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return exp_count;
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [frma_pkg::INTERVAL_BITS-1:0] in_frame_interval_us;
  logic                               out_valid;
  logic                               out_stall;
  logic [frma_pkg::RATE_W-1:0]        out_instant_rate;
  logic [frma_pkg::RATE_W-1:0]        out_average_rate;
  logic [frma_pkg::HELD_W-1:0]        out_samples_held;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [frma_pkg::WIN_W-1:0]         cfg_window_length;

  rate_window_scoreboard sb = new();

  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;
  bit          rx_long_req = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned windows_set = 0;

  // corner intervals: saturation edge, extremes, bit patterns, common frame times
  logic [frma_pkg::INTERVAL_BITS-1:0] corner_us [19] = '{
    20'd0, 20'd1, 20'd2, 20'd15, 20'd16, 20'd17, 20'd255, 20'd1000, 20'd3906,
    20'd15625, 20'd16667, 20'd33333, 20'd40000, 20'd100000, 20'h55555,
    20'hAAAAA, 20'h80000, 20'hFFFFE, 20'hFFFFF
  };

  // window settings: extremes, clamped values and a few in between
  logic [frma_pkg::WIN_W-1:0] window_sweep [10] = '{
    8'd1, 8'd128, 8'd0, 8'd255, 8'd2, 8'd3, 8'd129, 8'd7, 8'd50, 8'd100
  };

  frame_rate_moving_average_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_frame_interval_us (in_frame_interval_us),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_instant_rate     (out_instant_rate),
    .out_average_rate     (out_average_rate),
    .out_samples_held     (out_samples_held),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_window_length    (cfg_window_length)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly ordinary frame times, some near saturation, some over the whole range
  function automatic logic [frma_pkg::INTERVAL_BITS-1:0] draw_interval();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      return frma_pkg::INTERVAL_BITS'($urandom_range(0, 20));
    end else if (pick < 4) begin
      return frma_pkg::INTERVAL_BITS'($urandom());
    end
    return frma_pkg::INTERVAL_BITS'($urandom_range(4000, 70000));
  endfunction

  function automatic int unsigned phase_length(logic [frma_pkg::WIN_W-1:0] w);
    int unsigned span;
    if (w == '0) begin
      span = 1;
    end else if (int'(w) > frma_pkg::WINDOW_DEPTH) begin
      span = frma_pkg::WINDOW_DEPTH;
    end else begin
      span = int'(w);
    end
    return span + span / 2 + $urandom_range(8, 24);
  endfunction

  // offer one interval, hold it until taken
  task automatic send_interval(input logic [frma_pkg::INTERVAL_BITS-1:0] us);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_frame_interval_us <= us;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_interval(us);
    items_sent++;
  endtask

  task automatic write_window(input logic [frma_pkg::WIN_W-1:0] w);
    cfg_valid         <= 1'b1;
    cfg_window_length <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_window(w);
    windows_set++;
  endtask

  // wait for every outstanding result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned n_items);
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    repeat (n_items) send_interval(draw_interval());
    drain();
  endtask

  // result side: random stall per item, plus one long hold on request
  initial begin : result_sink
    int unsigned  hold_left;
    rate_result_t got;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.instant = out_instant_rate;
        got.average = out_average_rate;
        got.held    = out_samples_held;
        sb.check_result(got);
        hold_left = rx_quiet ? 0 : $urandom_range(0, 19);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      if (rx_long_req) begin
        rx_long_req = 1'b0;
        hold_left   = LONG_HOLD;
      end
      out_stall <= (hold_left > 0);
    end
  end

  // ends the run if no handshake completes for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // run sequence
  initial begin : stimulus
    logic [frma_pkg::WIN_W-1:0] w;
    int unsigned                n;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_frame_interval_us = '0;
    cfg_valid            = 1'b0;
    cfg_window_length    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners at the reset window, then enough to wrap it
    foreach (corner_us[i]) send_interval(corner_us[i]);
    run_phase(110);

    // sweep of window settings, long receiver hold in the deepest one
    foreach (window_sweep[i]) begin
      write_window(window_sweep[i]);
      if (window_sweep[i] == frma_pkg::WIN_W'(frma_pkg::WINDOW_DEPTH)) rx_long_req = 1'b1;
      run_phase(phase_length(window_sweep[i]));
    end

    // random windows until the item budget is spent
    while (items_sent < ITEM_TARGET) begin
      w = frma_pkg::WIN_W'($urandom_range(1, frma_pkg::WINDOW_DEPTH));
      write_window(w);
      n = phase_length(w);
      if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
      run_phase(n);
    end

    $display("run sent %0d frame intervals over %0d window writes, corners and wraps included",
             items_sent, windows_set);
    $display("%0d results compared, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
